// ===== rtl/core/selective_repeat_receive_window_macros.svh =====
// assertion macros for the receive window block
`ifndef SELECTIVE_REPEAT_RECEIVE_WINDOW_MACROS_SVH
`define SELECTIVE_REPEAT_RECEIVE_WINDOW_MACROS_SVH

`ifndef ASSERT_OFF

`define SRRW_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

`define SRRW_ASSERT_IMPLIES(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) else $error(msg);

`define SRRW_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) else $error(msg);

`else

`define SRRW_ASSERT_ALWAYS(label, cond, msg)

`define SRRW_ASSERT_IMPLIES(label, pre, post, msg)

`define SRRW_ASSERT_NEXT(label, pre, post, msg)

`endif

`endif

// ===== rtl/core/srrw_pkg.sv =====
// types and constants shared by the receive window modules
package srrw_pkg;

   localparam int WINDOW_SLOTS    = 32;
   localparam int PAYLOAD_BITS    = 64;
   localparam int SEQ_BITS        = 16;
   localparam int BASE_BITS       = SEQ_BITS + 1;
   localparam int WORD_BITS       = 64;
   localparam int SLOT_BITS       = $clog2(WINDOW_SLOTS);
   localparam int RUN_BITS        = $clog2(WINDOW_SLOTS + 1);
   localparam int CMD_QUEUE_DEPTH = 2;

   localparam logic KIND_ACK     = 1'b0;
   localparam logic KIND_DELIVER = 1'b1;

   typedef logic [WORD_BITS-1:0] payload_word_type;

   typedef struct packed {
      logic [SEQ_BITS-1:0] seq_number;
      payload_word_type    payload_word;
   } req_item_type;

   typedef struct packed {
      logic                result_kind;
      logic [SEQ_BITS-1:0] result_seq;
      payload_word_type    result_payload;
      logic                last_of_run;
      logic                transfer_done;
   } rsp_item_type;

   typedef struct packed {
      logic [SEQ_BITS-1:0] ack_seq;
      logic [SEQ_BITS-1:0] run_start;
      logic [RUN_BITS-1:0] run_len;
      logic                done;
   } cmd_type;

   typedef struct packed {
      logic run_done;
      logic busy;
   } back_status_type;

   typedef enum logic [1:0] {
      FRONT_IDLE,
      FRONT_SCAN,
      FRONT_PUSH
   } front_state_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_ACK,
      BACK_READ,
      BACK_LOAD
   } back_state_type;

endpackage

// ===== rtl/core/srrw_ram.sv =====
// generic single write port ram with registered read
module srrw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/srrw_front.sv =====
// front end: classifies packets, caches payloads, scans the in-order run
module srrw_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  srrw_pkg::req_item_type                req_data,
   input  logic [srrw_pkg::SEQ_BITS-1:0]         total_packets,
   input  logic                                  q_full,
   output logic                                  q_push,
   output srrw_pkg::cmd_type                     q_cmd,
   input  srrw_pkg::back_status_type             back_status,
   output logic                                  ram_wr_en,
   output logic [srrw_pkg::SLOT_BITS-1:0]        ram_wr_addr,
   output logic [srrw_pkg::PAYLOAD_BITS-1:0]     ram_wr_data
);

   srrw_pkg::front_state_type              state_ff, state_in;
   logic [srrw_pkg::BASE_BITS-1:0]         base_ff, base_in;
   logic [srrw_pkg::WINDOW_SLOTS-1:0]      filled_ff, filled_in;
   logic [srrw_pkg::RUN_BITS-1:0]          cnt_ff, cnt_in;
   logic [srrw_pkg::SEQ_BITS-1:0]          ack_seq_ff, ack_seq_in;
   logic                                   pending_ff, pending_in;

   logic [srrw_pkg::BASE_BITS-1:0]         seq_ext;
   logic [srrw_pkg::BASE_BITS-1:0]         lower;
   logic [srrw_pkg::BASE_BITS-1:0]         new_base;
   logic [srrw_pkg::BASE_BITS:0]           win_end;
   logic [srrw_pkg::SLOT_BITS-1:0]         slot;
   logic [srrw_pkg::SLOT_BITS-1:0]         scan_idx;
   logic                                   in_win;
   logic                                   is_old;
   logic                                   is_base;
   logic                                   accept;
   logic                                   scan_hit;

   assign seq_ext  = srrw_pkg::BASE_BITS'(req_data.seq_number);
   assign win_end  = {1'b0, base_ff} + (srrw_pkg::BASE_BITS + 1)'(srrw_pkg::WINDOW_SLOTS);
   assign lower    = (base_ff >= srrw_pkg::BASE_BITS'(srrw_pkg::WINDOW_SLOTS))
                   ? base_ff - srrw_pkg::BASE_BITS'(srrw_pkg::WINDOW_SLOTS)
                   : '0;
   assign in_win   = (seq_ext >= base_ff) && ({1'b0, seq_ext} < win_end);
   assign is_old   = (seq_ext >= lower) && (seq_ext < base_ff);
   assign is_base  = (seq_ext == base_ff);
   assign slot     = req_data.seq_number[srrw_pkg::SLOT_BITS-1:0];
   assign accept   = req_valid && req_ready;
   assign scan_idx = base_ff[srrw_pkg::SLOT_BITS-1:0] + cnt_ff[srrw_pkg::SLOT_BITS-1:0];
   assign scan_hit = (cnt_ff != srrw_pkg::RUN_BITS'(srrw_pkg::WINDOW_SLOTS))
                   && filled_ff[scan_idx];
   assign new_base = base_ff + srrw_pkg::BASE_BITS'(cnt_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         srrw_pkg::FRONT_IDLE: begin
            if (accept && in_win && is_base) begin
               state_in = srrw_pkg::FRONT_SCAN;
            end
         end
         srrw_pkg::FRONT_SCAN: begin
            if (!scan_hit) begin
               state_in = srrw_pkg::FRONT_PUSH;
            end
         end
         srrw_pkg::FRONT_PUSH: begin
            if (!q_full) begin
               state_in = srrw_pkg::FRONT_IDLE;
            end
         end
         default: state_in = srrw_pkg::FRONT_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_ready   = 1'b0;
      q_push      = 1'b0;
      q_cmd       = '0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = slot;
      ram_wr_data = srrw_pkg::PAYLOAD_BITS'(req_data.payload_word);
      base_in     = base_ff;
      filled_in   = filled_ff;
      cnt_in      = cnt_ff;
      ack_seq_in  = ack_seq_ff;
      pending_in  = pending_ff;
      if (back_status.run_done) begin
         pending_in = 1'b0;
      end
      case (state_ff)
         srrw_pkg::FRONT_IDLE: begin
            req_ready = !q_full && !pending_ff;
            if (accept) begin
               cnt_in     = '0;
               ack_seq_in = req_data.seq_number;
               if (in_win) begin
                  ram_wr_en       = !filled_ff[slot];
                  filled_in[slot] = 1'b1;
               end
               // ack only: window base does not move
               if (is_old || (in_win && !is_base)) begin
                  q_push          = 1'b1;
                  q_cmd.ack_seq   = req_data.seq_number;
                  q_cmd.run_start = base_ff[srrw_pkg::SEQ_BITS-1:0];
                  q_cmd.run_len   = '0;
                  q_cmd.done      = base_ff >= srrw_pkg::BASE_BITS'(total_packets);
               end
            end
         end
         srrw_pkg::FRONT_SCAN: begin
            if (scan_hit) begin
               filled_in[scan_idx] = 1'b0;
               cnt_in              = cnt_ff + 1'b1;
            end
         end
         srrw_pkg::FRONT_PUSH: begin
            q_cmd.ack_seq   = ack_seq_ff;
            q_cmd.run_start = base_ff[srrw_pkg::SEQ_BITS-1:0];
            q_cmd.run_len   = cnt_ff;
            q_cmd.done      = new_base >= srrw_pkg::BASE_BITS'(total_packets);
            if (!q_full) begin
               q_push     = 1'b1;
               base_in    = new_base;
               pending_in = 1'b1;
            end
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= srrw_pkg::FRONT_IDLE;
         base_ff    <= '0;
         filled_ff  <= '0;
         cnt_ff     <= '0;
         pending_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         base_ff    <= base_in;
         filled_ff  <= filled_in;
         cnt_ff     <= cnt_in;
         pending_ff <= pending_in;
      end
   end

   always_ff @(posedge clock) begin
      ack_seq_ff <= ack_seq_in;
   end

endmodule

// ===== rtl/core/srrw_cmd_queue.sv =====
// short command queue between front and back
module srrw_cmd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  srrw_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output srrw_pkg::cmd_type pop_cmd,
   output logic              empty
);

   localparam int PTR_BITS = (srrw_pkg::CMD_QUEUE_DEPTH > 1)
                           ? $clog2(srrw_pkg::CMD_QUEUE_DEPTH) : 1;
   localparam int CNT_BITS = $clog2(srrw_pkg::CMD_QUEUE_DEPTH + 1);

   srrw_pkg::cmd_type      entry_ff [srrw_pkg::CMD_QUEUE_DEPTH];
   logic [PTR_BITS-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]    count_ff, count_in;
   logic                   do_push;
   logic                   do_pop;

   assign full    = (count_ff == CNT_BITS'(srrw_pkg::CMD_QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign pop_cmd = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(srrw_pkg::CMD_QUEUE_DEPTH - 1))
                   ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(srrw_pkg::CMD_QUEUE_DEPTH - 1))
                   ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== rtl/core/srrw_back.sv =====
// back end: emits the ack and then reads out the delivered run
module srrw_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              q_empty,
   output logic                              q_pop,
   input  srrw_pkg::cmd_type                 q_cmd,
   output logic                              ram_rd_en,
   output logic [srrw_pkg::SLOT_BITS-1:0]    ram_rd_addr,
   input  logic [srrw_pkg::PAYLOAD_BITS-1:0] ram_rd_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output srrw_pkg::rsp_item_type            rsp_data,
   output srrw_pkg::back_status_type         back_status
);

   srrw_pkg::back_state_type       state_ff, state_in;
   srrw_pkg::cmd_type              cur_ff, cur_in;
   logic [srrw_pkg::RUN_BITS-1:0]  idx_ff, idx_in;
   logic                           rsp_valid_ff;
   srrw_pkg::rsp_item_type         rsp_data_ff;
   srrw_pkg::rsp_item_type         out_item;
   logic                           out_load;
   logic                           out_free;
   logic                           last_del;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign last_del = (idx_ff == cur_ff.run_len - 1'b1);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         srrw_pkg::BACK_IDLE: begin
            if (!q_empty) begin
               state_in = srrw_pkg::BACK_ACK;
            end
         end
         srrw_pkg::BACK_ACK: begin
            if (out_free) begin
               state_in = (cur_ff.run_len == '0) ? srrw_pkg::BACK_IDLE : srrw_pkg::BACK_READ;
            end
         end
         srrw_pkg::BACK_READ: begin
            state_in = srrw_pkg::BACK_LOAD;
         end
         srrw_pkg::BACK_LOAD: begin
            if (out_free) begin
               state_in = last_del ? srrw_pkg::BACK_IDLE : srrw_pkg::BACK_READ;
            end
         end
         default: state_in = srrw_pkg::BACK_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      q_pop       = 1'b0;
      ram_rd_en   = 1'b0;
      ram_rd_addr = cur_ff.run_start[srrw_pkg::SLOT_BITS-1:0]
                  + idx_ff[srrw_pkg::SLOT_BITS-1:0];
      out_load    = 1'b0;
      out_item    = '0;
      cur_in      = cur_ff;
      idx_in      = idx_ff;
      back_status = '0;
      back_status.busy = (state_ff != srrw_pkg::BACK_IDLE);
      out_item.transfer_done = cur_ff.done;
      case (state_ff)
         srrw_pkg::BACK_IDLE: begin
            q_pop = !q_empty;
            if (!q_empty) begin
               cur_in = q_cmd;
               idx_in = '0;
            end
         end
         srrw_pkg::BACK_ACK: begin
            out_load             = out_free;
            out_item.result_kind = srrw_pkg::KIND_ACK;
            out_item.result_seq  = cur_ff.ack_seq;
            out_item.last_of_run = (cur_ff.run_len == '0);
         end
         srrw_pkg::BACK_READ: begin
            ram_rd_en = 1'b1;
         end
         srrw_pkg::BACK_LOAD: begin
            out_load                = out_free;
            out_item.result_kind    = srrw_pkg::KIND_DELIVER;
            out_item.result_seq     = cur_ff.run_start + srrw_pkg::SEQ_BITS'(idx_ff);
            out_item.result_payload = srrw_pkg::payload_word_type'(ram_rd_data);
            out_item.last_of_run    = last_del;
            if (out_free) begin
               idx_in               = idx_ff + 1'b1;
               back_status.run_done = last_del;
            end
         end
         default: begin
            out_load = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= srrw_pkg::BACK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      idx_ff <= idx_in;
      if (out_load) begin
         rsp_data_ff <= out_item;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/core/selective_repeat_receive_window.sv =====
// top level of the selective-repeat receive window
//
//   channel   dir  handshake             carries
//   req_*     in   req_valid/req_ready   seq_number, payload_word
//   rsp_*     out  rsp_valid/rsp_ready   kind, seq, payload, last_of_run, transfer_done
//   csr_*     in   csr_valid/csr_ready   total_packets
//
// an ack-only packet leaves the front idle; its ack goes via the command queue and the
// back end's ack state to the rsp register, later when queued behind earlier items or
// held by rsp_ready; the back end reads each delivery from the ram, then loads it out
// a packet at the window base holds the front through accept, a scan of its run's slots
// and push; while its deliveries are outstanding no new packet is taken
// reset is synchronous and clears the window at once; no clearing pass is needed
`include "selective_repeat_receive_window_macros.svh"

module selective_repeat_receive_window (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  srrw_pkg::req_item_type        req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output srrw_pkg::rsp_item_type        rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [srrw_pkg::SEQ_BITS-1:0] csr_data
);

   logic [srrw_pkg::SEQ_BITS-1:0]     total_packets_ff;
   logic                              q_push;
   logic                              q_pop;
   logic                              q_full;
   logic                              q_empty;
   srrw_pkg::cmd_type                 push_cmd;
   srrw_pkg::cmd_type                 pop_cmd;
   srrw_pkg::back_status_type         back_status;
   logic                              ram_wr_en;
   logic [srrw_pkg::SLOT_BITS-1:0]    ram_wr_addr;
   logic [srrw_pkg::PAYLOAD_BITS-1:0] ram_wr_data;
   logic                              ram_rd_en;
   logic [srrw_pkg::SLOT_BITS-1:0]    ram_rd_addr;
   logic [srrw_pkg::PAYLOAD_BITS-1:0] ram_rd_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         total_packets_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         total_packets_ff <= csr_data;
      end
   end

   srrw_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .total_packets (total_packets_ff),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_cmd         (push_cmd),
      .back_status   (back_status),
      .ram_wr_en     (ram_wr_en),
      .ram_wr_addr   (ram_wr_addr),
      .ram_wr_data   (ram_wr_data)
   );

   srrw_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .pop_cmd  (pop_cmd),
      .empty    (q_empty)
   );

   srrw_ram #(
      .WIDTH (srrw_pkg::PAYLOAD_BITS),
      .DEPTH (srrw_pkg::WINDOW_SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   srrw_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_empty     (q_empty),
      .q_pop       (q_pop),
      .q_cmd       (pop_cmd),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .back_status (back_status)
   );

   `SRRW_ASSERT_IMPLIES(a_no_push_when_full, q_push && q_full, 1'b0, "command pushed into full queue")
   `SRRW_ASSERT_IMPLIES(a_no_pop_when_empty, q_pop && q_empty, 1'b0, "command popped from empty queue")
   `SRRW_ASSERT_IMPLIES(a_ack_has_no_payload, rsp_valid && (rsp_data.result_kind == srrw_pkg::KIND_ACK), rsp_data.result_payload == '0, "ack carries a payload")
   `SRRW_ASSERT_IMPLIES(a_ram_ports_apart, ram_wr_en && ram_rd_en && back_status.busy, ram_wr_addr != ram_rd_addr, "slot written while run reads it")
   `SRRW_ASSERT_NEXT(a_run_done_frees_back, back_status.run_done, !back_status.busy, "back end still busy after its run")

endmodule
